// ===== src/csv_field_splitter_macros.svh =====
// assertion macros for the csv field splitter checker
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

// checked at every edge outside reset
`define CSVFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CSVFS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/csvfs_pkg.sv =====
`timescale 1ns / 1ps

package csvfs_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_QUOTE = 8'd34;

   localparam logic [7:0] SEP_A_RESET      = 8'd44;
   localparam logic [7:0] SEP_OTHER_RESET  = 8'd0;
   localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;
   localparam logic [7:0] FIELD_INDEX_MAX  = 8'd255;

   // register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_SEP_A      = 3'd0,
      REG_SEP_B      = 3'd1,
      REG_SEP_C      = 3'd2,
      REG_SEP_D      = 3'd3,
      REG_MAX_FIELDS = 3'd4
   } csvfs_reg_type;

   typedef struct packed {
      logic [7:0] sep_a;
      logic [7:0] sep_b;
      logic [7:0] sep_c;
      logic [7:0] sep_d;
      logic [7:0] max_fields;
   } csvfs_cfg_type;

   typedef struct packed {
      logic       at_field_start;
      logic       quote_led_field;
      logic       inside_quotes;
      logic       pending_quote;
      logic       skip_to_newline;
      logic       line_open;
      logic [7:0] field_index;
   } csvfs_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
      logic [7:0] field_number;
   } csvfs_result_type;

   localparam csvfs_state_type STATE_FRESH = '{
      at_field_start:  1'b1,
      quote_led_field: 1'b0,
      inside_quotes:   1'b0,
      pending_quote:   1'b0,
      skip_to_newline: 1'b0,
      line_open:       1'b0,
      field_index:     8'd0
   };

endpackage

// ===== src/csvfs_csr.sv =====
`timescale 1ns / 1ps

module csvfs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [csvfs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [csvfs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output csvfs_pkg::csvfs_cfg_type          cfg
);

   csvfs_pkg::csvfs_cfg_type cfg_ff, cfg_in;
   csvfs_pkg::csvfs_reg_type reg_sel;
   logic                     wr_en;
   logic [7:0]               rd_val;

   assign reg_sel = csvfs_pkg::csvfs_reg_type'(csr_paddr[4:2]);
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            csvfs_pkg::REG_SEP_A:      cfg_in.sep_a      = csr_pwdata[7:0];
            csvfs_pkg::REG_SEP_B:      cfg_in.sep_b      = csr_pwdata[7:0];
            csvfs_pkg::REG_SEP_C:      cfg_in.sep_c      = csr_pwdata[7:0];
            csvfs_pkg::REG_SEP_D:      cfg_in.sep_d      = csr_pwdata[7:0];
            csvfs_pkg::REG_MAX_FIELDS: cfg_in.max_fields = csr_pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         csvfs_pkg::REG_SEP_A:      rd_val = cfg_ff.sep_a;
         csvfs_pkg::REG_SEP_B:      rd_val = cfg_ff.sep_b;
         csvfs_pkg::REG_SEP_C:      rd_val = cfg_ff.sep_c;
         csvfs_pkg::REG_SEP_D:      rd_val = cfg_ff.sep_d;
         csvfs_pkg::REG_MAX_FIELDS: rd_val = cfg_ff.max_fields;
         default:                   rd_val = 8'd0;
      endcase
   end

   assign csr_prdata = {{(csvfs_pkg::CSR_DATA_W-8){1'b0}}, rd_val};
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sep_a      <= csvfs_pkg::SEP_A_RESET;
         cfg_ff.sep_b      <= csvfs_pkg::SEP_OTHER_RESET;
         cfg_ff.sep_c      <= csvfs_pkg::SEP_OTHER_RESET;
         cfg_ff.sep_d      <= csvfs_pkg::SEP_OTHER_RESET;
         cfg_ff.max_fields <= csvfs_pkg::MAX_FIELDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/csvfs_parse.sv =====
`timescale 1ns / 1ps

module csvfs_parse (
   input  csvfs_pkg::csvfs_cfg_type    cfg,
   input  csvfs_pkg::csvfs_state_type  st,
   input  logic                        op,
   input  logic [7:0]                  in_byte,
   output csvfs_pkg::csvfs_state_type  st_next,
   output logic                        emit,
   output csvfs_pkg::csvfs_result_type res
);

   logic kept;
   logic is_sep;
   logic is_quote;
   logic inq;
   logic quote_pair;

   assign kept     = st.field_index < cfg.max_fields;
   assign is_quote = in_byte == csvfs_pkg::CH_QUOTE;
   assign is_sep   = (in_byte != csvfs_pkg::CH_NUL) &&
                     ((in_byte == cfg.sep_a) || (in_byte == cfg.sep_b) ||
                      (in_byte == cfg.sep_c) || (in_byte == cfg.sep_d));

   always_comb begin
      st_next          = st;
      emit             = 1'b0;
      res.out_byte     = 8'd0;
      res.byte_valid   = 1'b0;
      res.field_end    = 1'b0;
      res.line_end     = 1'b0;
      res.field_number = st.field_index;
      inq              = st.inside_quotes;
      quote_pair       = 1'b0;

      if (op) begin
         // end of stream closes an open line
         if (st.line_open) begin
            emit          = 1'b1;
            res.field_end = kept;
            res.line_end  = 1'b1;
         end
         st_next = csvfs_pkg::STATE_FRESH;
      end else if (in_byte == csvfs_pkg::CH_LF) begin
         emit          = 1'b1;
         res.field_end = kept;
         res.line_end  = 1'b1;
         st_next       = csvfs_pkg::STATE_FRESH;
      end else begin
         st_next.line_open = 1'b1;
         if (st.skip_to_newline) begin
            // ignore up to lf
         end else if ((in_byte == csvfs_pkg::CH_CR) || (in_byte == csvfs_pkg::CH_NUL)) begin
            st_next.skip_to_newline = 1'b1;
            st_next.pending_quote   = 1'b0;
         end else begin
            // resolve a quote seen on the previous byte
            if (st.pending_quote) begin
               st_next.pending_quote = 1'b0;
               if (is_quote) begin
                  quote_pair     = 1'b1;
                  emit           = kept;
                  res.out_byte   = csvfs_pkg::CH_QUOTE;
                  res.byte_valid = 1'b1;
               end else begin
                  inq                   = ~st.inside_quotes;
                  st_next.inside_quotes = inq;
               end
            end
            if (!quote_pair) begin
               st_next.at_field_start = 1'b0;
               if (st.at_field_start && is_quote) begin
                  st_next.quote_led_field = 1'b1;
                  st_next.pending_quote   = 1'b1;
               end else if (st.quote_led_field && is_quote) begin
                  st_next.pending_quote = 1'b1;
               end else if (is_sep && !(st.quote_led_field && inq)) begin
                  emit          = kept;
                  res.field_end = 1'b1;
                  if (st.field_index != csvfs_pkg::FIELD_INDEX_MAX) begin
                     st_next.field_index = st.field_index + 8'd1;
                  end
                  st_next.at_field_start  = 1'b1;
                  st_next.quote_led_field = 1'b0;
                  st_next.inside_quotes   = 1'b0;
               end else if (is_quote) begin
                  st_next.pending_quote = 1'b1;
               end else begin
                  emit           = kept;
                  res.out_byte   = in_byte;
                  res.byte_valid = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== src/csv_field_splitter.sv =====
`timescale 1ns / 1ps
// csv field splitter: splits a text stream into fields, one byte per beat
// req channel: req_tdata is the text byte, req_tuser is the op flag
//   (0 = text byte, 1 = end of stream, which closes any open line)
// rsp channel: one beat per byte, field end or line end that yields a result;
//   rsp_tdata carries the unescaped byte and the field number, rsp_tuser
//   byte_valid and field_end, rsp_tlast marks the end of a line
// csr port: separators sep_a..sep_d at 0x0..0xc, max_fields at 0x10;
//   write only while the block is idle
// path: a taken req beat waits in the input register, and its result beat is
//   presented on rsp from the result register
// throughput: one req beat per cycle while rsp is not stalled, set by the
//   combinational parse step between the input register and the result register
// stall: the result register holds while rsp_tready is low; the input
//   register still fills, and req_tready drops only when both are full
// reset: synchronous; clears both valids, the line state and the registers
//   to their defaults (comma separator, 16 fields kept)

module csv_field_splitter (
   input  logic                             clock,
   input  logic                             reset,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] in_byte
   input  logic                             req_tuser,   // [0] op
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [7:0] out_byte, [15:8] field_number
   output logic [1:0]                       rsp_tuser,   // [0] byte_valid, [1] field_end
   output logic                             rsp_tlast,   // line_end
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [csvfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [csvfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   csvfs_pkg::csvfs_cfg_type    cfg;
   csvfs_pkg::csvfs_state_type  state_ff, state_in;
   csvfs_pkg::csvfs_result_type res_calc;
   csvfs_pkg::csvfs_result_type res_ff;
   logic                        emit;

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       take_req;

   assign csr_pready = 1'b1;

   csvfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   csvfs_parse u_parse (
      .cfg     (cfg),
      .st      (state_ff),
      .op      (in_op_ff),
      .in_byte (in_byte_ff),
      .st_next (state_in),
      .emit    (emit),
      .res     (res_calc)
   );

   // the held beat moves on whenever the result register is free or draining
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign take_req   = req_tvalid & req_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= csvfs_pkg::STATE_FRESH;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance & emit) begin
         res_ff <= res_calc;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_ff.field_number, res_ff.out_byte};
   assign rsp_tuser  = {res_ff.field_end, res_ff.byte_valid};
   assign rsp_tlast  = res_ff.line_end;

endmodule

// ===== src/csvfs_checker.sv =====
`timescale 1ns / 1ps
`include "csv_field_splitter_macros.svh"

module csvfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic        rsp_stall;
   logic [18:0] rsp_beat;
   logic        line_end_beat;
   logic        byte_lane_clear;

   assign rsp_stall       = rsp_tvalid && !rsp_tready;
   assign rsp_beat        = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign line_end_beat   = rsp_tvalid && rsp_tlast;
   assign byte_lane_clear = !rsp_tuser[0] && (rsp_tdata[7:0] == 8'd0);

   // a stalled result beat stays put
   `CSVFS_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "rsp beat changed")

   // a beat carries at most one of byte, field end
   `CSVFS_ASSERT(a_one_kind, rsp_tvalid |-> !(&rsp_tuser), "byte and field end together")

   // a line end carries no byte and a zero byte lane
   `CSVFS_ASSERT(a_line_end_empty, line_end_beat |-> byte_lane_clear, "line end with byte")

   // no result right after reset
   `CSVFS_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

// ===== tb/sv/csv_field_splitter_check.sv =====
`timescale 1ns / 1ps

// watches both streams and the csr port, predicts the parser's results and
// compares every result beat with the oldest prediction
module csv_field_splitter_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] in_byte
   input  logic                             req_tuser,   // [0] op
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,   // [7:0] out_byte, [15:8] field_number
   input  logic [1:0]                       rsp_tuser,   // [0] byte_valid, [1] field_end
   input  logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [csvfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending_count
);

   import csvfs_pkg::*;

   csvfs_cfg_type    split_cfg;
   csvfs_state_type  line_st;
   csvfs_result_type field_results_q[$];
   int               errors = 0;

   function automatic csvfs_result_type make_result(input logic [7:0] b, input logic bv,
                                                    input logic fe, input logic le);
      csvfs_result_type r;
      r.out_byte     = b;
      r.byte_valid   = bv;
      r.field_end    = fe;
      r.line_end     = le;
      r.field_number = line_st.field_index;
      return r;
   endfunction

   // one input beat through the splitter; returns 1 when a result comes out
   function automatic bit split_step(input logic end_of_stream, input logic [7:0] ch,
                                     output csvfs_result_type res);
      logic kept;
      logic is_sep;
      res = '0;
      if (end_of_stream || ch == CH_LF) begin
         // end of stream only closes a line that has seen a byte
         if (!end_of_stream || line_st.line_open) begin
            res = make_result(8'd0, 1'b0, line_st.field_index < split_cfg.max_fields, 1'b1);
            line_st = STATE_FRESH;
            return 1'b1;
         end
         line_st = STATE_FRESH;
         return 1'b0;
      end
      line_st.line_open = 1'b1;
      if (line_st.skip_to_newline)
         return 1'b0;
      if (ch == CH_CR || ch == CH_NUL) begin
         line_st.skip_to_newline = 1'b1;
         line_st.pending_quote   = 1'b0;
         return 1'b0;
      end
      kept = line_st.field_index < split_cfg.max_fields;
      // a held quote is resolved by the byte after it
      if (line_st.pending_quote) begin
         line_st.pending_quote = 1'b0;
         if (ch == CH_QUOTE) begin
            res = make_result(CH_QUOTE, 1'b1, 1'b0, 1'b0);
            return kept;
         end
         line_st.inside_quotes = !line_st.inside_quotes;
      end
      if (line_st.at_field_start && ch == CH_QUOTE) begin
         line_st.at_field_start  = 1'b0;
         line_st.quote_led_field = 1'b1;
         line_st.pending_quote   = 1'b1;
         return 1'b0;
      end
      line_st.at_field_start = 1'b0;
      if (line_st.quote_led_field && ch == CH_QUOTE) begin
         line_st.pending_quote = 1'b1;
         return 1'b0;
      end
      // ch is never nul here, so an unused (zero) separator cannot match
      is_sep = ch == split_cfg.sep_a || ch == split_cfg.sep_b ||
               ch == split_cfg.sep_c || ch == split_cfg.sep_d;
      if (is_sep && !(line_st.quote_led_field && line_st.inside_quotes)) begin
         res = make_result(8'd0, 1'b0, 1'b1, 1'b0);
         if (line_st.field_index != FIELD_INDEX_MAX)
            line_st.field_index = line_st.field_index + 8'd1;
         line_st.at_field_start  = 1'b1;
         line_st.quote_led_field = 1'b0;
         line_st.inside_quotes   = 1'b0;
         return kept;
      end
      if (ch == CH_QUOTE) begin
         line_st.pending_quote = 1'b1;
         return 1'b0;
      end
      res = make_result(ch, 1'b1, 1'b0, 1'b0);
      return kept;
   endfunction

   function automatic int field_mismatch(input string what, input int want, input int got);
      if (want == got)
         return 0;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      csvfs_result_type seen;
      csvfs_result_type want;
      if (reset) begin
         split_cfg = '{SEP_A_RESET, SEP_OTHER_RESET, SEP_OTHER_RESET, SEP_OTHER_RESET,
                       MAX_FIELDS_RESET};
         line_st = STATE_FRESH;
         field_results_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csvfs_reg_type'(csr_paddr[4:2]))
               REG_SEP_A:      split_cfg.sep_a      = csr_pwdata[7:0];
               REG_SEP_B:      split_cfg.sep_b      = csr_pwdata[7:0];
               REG_SEP_C:      split_cfg.sep_c      = csr_pwdata[7:0];
               REG_SEP_D:      split_cfg.sep_d      = csr_pwdata[7:0];
               REG_MAX_FIELDS: split_cfg.max_fields = csr_pwdata[7:0];
               default: ;
            endcase
         end
         // pop before push: a result beat can never belong to the beat taken now
         if (rsp_tvalid && rsp_tready) begin
            seen.out_byte     = rsp_tdata[7:0];
            seen.field_number = rsp_tdata[15:8];
            seen.byte_valid   = rsp_tuser[0];
            seen.field_end    = rsp_tuser[1];
            seen.line_end     = rsp_tlast;
            if (field_results_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, seen);
               errors++;
            end else begin
               want = field_results_q.pop_front();
               errors += field_mismatch("out_byte", int'(want.out_byte),
                                        int'(seen.out_byte));
               errors += field_mismatch("byte_valid", int'(want.byte_valid),
                                        int'(seen.byte_valid));
               errors += field_mismatch("field_end", int'(want.field_end),
                                        int'(seen.field_end));
               errors += field_mismatch("line_end", int'(want.line_end),
                                        int'(seen.line_end));
               errors += field_mismatch("field_number", int'(want.field_number),
                                        int'(seen.field_number));
            end
         end
         if (req_tvalid && req_tready) begin
            if (split_step(req_tuser, req_tdata, want))
               field_results_q.push_back(want);
         end
      end
      fail_count    <= errors;
      pending_count <= field_results_q.size();
   end

endmodule

// ===== tb/sv/csv_field_splitter_test.sv =====
`timescale 1ns / 1ps

// top of the bench: clock, reset, csr writes, back-pressure and the text byte stream;
// the checker beside the block does all prediction and comparison
module csv_field_splitter_test;

   import csvfs_pkg::*;

   // op flag carried on req_tuser
   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES = 6;       // lets a taken beat pass the input and result registers
   localparam int N_PHASES      = 6;
   localparam int PHASE_BEATS   = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;   // [7:0] in_byte
   logic                  req_tuser = 1'b0;   // [0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [15:0]           rsp_tdata;          // [7:0] out_byte, [15:8] field_number
   logic [1:0]            rsp_tuser;          // [0] byte_valid, [1] field_end
   logic                  rsp_tlast;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   int                    beats_sent = 0;
   int                    burst_left = 0;

   // the separators currently programmed, used to build well-formed lines
   logic [7:0]            live_seps [4] = '{8'd44, 8'd0, 8'd0, 8'd0};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   csv_field_splitter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   csv_field_splitter_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver back-pressure: the pattern is picked by cycle_count[9:8], so stalls
   // land on every phase of the parse; one of the four modes never stalls
   always @(posedge clock) begin
      case (cycle_count[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(3) != 0);
         2'd2:    rsp_tready <= (cycle_count[3:0] < 4'd5);
         default: rsp_tready <= ($urandom_range(5) == 0);
      endcase
   end

   // one csr write: setup phase, then access phase until pready
   task automatic csr_write(input csvfs_reg_type idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                                input logic [7:0] d, input logic [7:0] keep);
      csr_write(REG_SEP_A, a);
      csr_write(REG_SEP_B, b);
      csr_write(REG_SEP_C, c);
      csr_write(REG_SEP_D, d);
      csr_write(REG_MAX_FIELDS, keep);
      live_seps = '{a, b, c, d};
   endtask

   // sender: bursts of random length, random gaps in between; valid is only
   // dropped when a real gap follows, so it never toggles within one step
   task automatic put_beat(input logic op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_beat(OP_TEXT, s[i]);
   endtask

   // hold off the sender until every predicted result is out and the
   // pipeline has had time to swallow beats that give no result
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // a separator that is live now, or a plain letter when none is
   function automatic logic [7:0] pick_sep();
      logic [7:0] live[$];
      foreach (live_seps[i])
         if (live_seps[i] != 8'd0) live.push_back(live_seps[i]);
      if (live.size() == 0)
         return 8'($urandom_range(97, 122));
      return live[$urandom_range(live.size() - 1)];
   endfunction

   // one field body; quote-led fields carry separators and doubled quotes
   task automatic send_field(input bit tiny);
      int len;
      int pick;
      len = tiny ? 0 : $urandom_range(0, 6);
      if ($urandom_range(2) == 0) begin
         put_beat(OP_TEXT, CH_QUOTE);
         repeat (len) begin
            pick = $urandom_range(9);
            if (pick < 6) put_beat(OP_TEXT, 8'($urandom_range(97, 122)));
            else if (pick < 7) put_beat(OP_TEXT, pick_sep());
            else if (pick < 9) begin
               put_beat(OP_TEXT, CH_QUOTE);
               put_beat(OP_TEXT, CH_QUOTE);
            end else put_beat(OP_TEXT, 8'($urandom_range(255)));
         end
         put_beat(OP_TEXT, CH_QUOTE);
         // text after the closing quote
         if ($urandom_range(7) == 0) put_beat(OP_TEXT, 8'($urandom_range(97, 122)));
      end else begin
         repeat (len) begin
            pick = $urandom_range(19);
            if (pick < 16) put_beat(OP_TEXT, 8'($urandom_range(97, 122)));
            else if (pick < 17) put_beat(OP_TEXT, CH_QUOTE);
            else put_beat(OP_TEXT, 8'($urandom_range(255)));
         end
      end
   endtask

   // one record line: mostly well formed, some noise and broken endings
   task automatic send_line(input bit long_line);
      int n_fields;
      int pick;
      if (!long_line && $urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) put_beat(OP_TEXT, 8'($urandom_range(255)));
         return;
      end
      n_fields = long_line ? 258 : $urandom_range(1, 5);
      if (!long_line && $urandom_range(7) == 0)
         n_fields = $urandom_range(6, 20);
      for (int f = 0; f < n_fields; f++) begin
         if (f > 0) put_beat(OP_TEXT, pick_sep());
         send_field(long_line);
      end
      pick = $urandom_range(99);
      if (pick < 78) put_beat(OP_TEXT, CH_LF);
      else if (pick < 88) begin
         // cr or nul, then junk that must be skipped up to lf
         put_beat(OP_TEXT, ($urandom_range(1) == 0) ? CH_CR : CH_NUL);
         repeat ($urandom_range(0, 3)) put_beat(OP_TEXT, 8'($urandom_range(255)));
         put_beat(OP_TEXT, CH_LF);
      end else if (pick < 96) begin
         put_beat(OP_END, 8'($urandom_range(255)));
         if ($urandom_range(2) == 0) put_beat(OP_END, 8'($urandom_range(255)));
      end
      // else the line runs on into the next one
   endtask

   task automatic set_phase(input int p);
      case (p)
         0:       apply_setting(8'd44, 8'd0, 8'd0, 8'd0, 8'd16);
         1:       apply_setting(8'd44, 8'd59, 8'd9, 8'd124, 8'd3);
         2:       apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
         3:       apply_setting(8'd255, CH_QUOTE, 8'd44, 8'd0, 8'd1);
         4:       apply_setting(8'd44, 8'd0, 8'd0, 8'd0, 8'd0);
         default: apply_setting(8'd59, 8'd44, 8'd0, 8'd0, 8'd255);
      endcase
   endtask

   initial begin
      int goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: quoted field holding a comma and a doubled
      // quote, lone quote in a plain field, cr with skipped bytes, empty line
      send_text("\"a,\"\"b\",x\"y");
      put_beat(OP_TEXT, CH_CR);
      send_text("\"z\n");
      put_beat(OP_TEXT, CH_LF);
      // byte extremes, nul skip, end of stream with and without an open line
      put_beat(OP_TEXT, 8'hff);
      put_beat(OP_TEXT, CH_NUL);
      put_beat(OP_TEXT, "q");
      put_beat(OP_END, 8'h5a);
      put_beat(OP_END, 8'ha5);
      // lf inside an open quote still ends the line
      send_text("\"p\n");

      // random phases, each under its own register setting; the last one
      // starts with a line long enough to saturate the field index
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         set_phase(p);
         goal = beats_sent + PHASE_BEATS;
         if (p == N_PHASES - 1) send_line(1'b1);
         while (beats_sent < goal) send_line(1'b0);
      end

      wait_idle();
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
